[rtl/core/shsp_pkg.sv]
// Shared types and constants for the selective hue/saturation pixel block.
`default_nettype none

package shsp_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 20;
	localparam int CFG_W      = 60;
	localparam int MAT_W      = 23;  // matrix result after the Q16 floor shift
	localparam int DELTA_W    = 35;  // blend step added to the original sample

	localparam logic [5:0]  ALL_CLASSES = 6'h3F;
	localparam logic [14:0] STRONG_GAIN = 15'd25344;  // 99.0 in Q8.8

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_COEF_RED   = 3'd0,
		CFG_COEF_GREEN = 3'd1,
		CFG_COEF_BLUE  = 3'd2,
		CFG_SELECT     = 3'd3,
		CFG_STRENGTH   = 3'd4,
		CFG_WIDE       = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red_in;
		logic [SAMPLE_W-1:0] green_in;
		logic [SAMPLE_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red_out;
		logic [SAMPLE_W-1:0] green_out;
		logic [SAMPLE_W-1:0] blue_out;
	} pix_out_t;

	// per-stage advance strobes handed to the blend lanes
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

`default_nettype wire

[rtl/core/shsp_blend_lane.sv]
// One channel of the blend: stages 3 to 6, from matrix result to clipped sample.
`default_nettype none

module shsp_blend_lane (
	input  wire logic                                 clk,
	input  wire shsp_pkg::stage_en_t                  en,
	input  wire logic                                 wide,
	input  wire logic                                 direct,
	input  wire logic signed [shsp_pkg::MAT_W-1:0]    m,
	input  wire logic        [shsp_pkg::SAMPLE_W-1:0] v0,
	input  wire logic        [shsp_pkg::SAMPLE_W-1:0] fs,
	output logic             [shsp_pkg::SAMPLE_W-1:0] sample
);

	// stage 3 : difference times weight
	logic signed [23:0] diff;
	logic signed [40:0] prod_s3;
	logic signed [shsp_pkg::MAT_W-1:0]    m_s3;
	logic        [shsp_pkg::SAMPLE_W-1:0] v0_s3;
	logic                                 direct_s3;

	assign diff = $signed({m[shsp_pkg::MAT_W-1], m}) - $signed({8'd0, v0});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3   <= diff * $signed({1'b0, fs});
			m_s3      <= m;
			v0_s3     <= v0;
			direct_s3 <= direct;
		end
	end

	// stage 4 : 8-bit rounding, or first estimate of /65535
	logic signed [41:0] rnd;
	logic signed [50:0] rnd257;
	logic        [40:0] mag_full;
	logic        [39:0] mag;
	logic        [40:0] recip_sum;

	logic signed [shsp_pkg::DELTA_W-1:0]  d8_s4;
	logic        [39:0]                   mag_s4;
	logic        [24:0]                   q0_s4;
	logic                                 neg_s4;
	logic signed [shsp_pkg::MAT_W-1:0]    m_s4;
	logic        [shsp_pkg::SAMPLE_W-1:0] v0_s4;
	logic                                 direct_s4;

	assign rnd       = $signed({prod_s3[40], prod_s3}) + 42'sd128;
	assign rnd257    = $signed({rnd, 8'd0}) + $signed({{9{rnd[41]}}, rnd});
	assign mag_full  = prod_s3[40] ? 41'(-prod_s3) : prod_s3;
	assign mag       = mag_full[39:0];
	// 1/65535 = 2^-16 (1 + 2^-16 + 2^-32 + ...); estimate is low by at most one
	assign recip_sum = {1'b0, mag} + {17'd0, mag[39:16]} + {33'd0, mag[39:32]};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			d8_s4     <= rnd257[50:16];
			mag_s4    <= mag;
			q0_s4     <= recip_sum[40:16];
			neg_s4    <= prod_s3[40];
			m_s4      <= m_s3;
			v0_s4     <= v0_s3;
			direct_s4 <= direct_s3;
		end
	end

	// stage 5 : quotient correction, sign restore
	logic signed [41:0] rem;
	logic        [25:0] quo;
	logic signed [shsp_pkg::DELTA_W-1:0] d16;

	logic signed [shsp_pkg::DELTA_W-1:0]  delta_s5;
	logic signed [shsp_pkg::MAT_W-1:0]    m_s5;
	logic        [shsp_pkg::SAMPLE_W-1:0] v0_s5;
	logic                                 direct_s5;

	assign rem = $signed({2'd0, mag_s4}) - $signed({1'b0, q0_s4, 16'd0})
		+ $signed({17'd0, q0_s4});
	assign quo = {1'b0, q0_s4} + {25'd0, (rem >= 42'sd65535)};
	assign d16 = neg_s4 ? -$signed({9'd0, quo}) : $signed({9'd0, quo});

	always_ff @(posedge clk) begin
		if (en.s5) begin
			delta_s5  <= wide ? d16 : d8_s4;
			m_s5      <= m_s4;
			v0_s5     <= v0_s4;
			direct_s5 <= direct_s4;
		end
	end

	// stage 6 : apply and clip
	logic signed [shsp_pkg::DELTA_W:0]  val;
	logic        [shsp_pkg::SAMPLE_W-1:0] maxv;

	assign maxv = wide ? 16'hFFFF : 16'h00FF;
	assign val  = direct_s5
		? $signed({{(shsp_pkg::DELTA_W + 1 - shsp_pkg::MAT_W){m_s5[shsp_pkg::MAT_W-1]}}, m_s5})
		: $signed({20'd0, v0_s5}) + $signed({delta_s5[shsp_pkg::DELTA_W-1], delta_s5});

	always_ff @(posedge clk) begin
		if (en.s6) begin
			if (val < 0) begin
				sample <= '0;
			end else if (val > $signed({20'd0, maxv})) begin
				sample <= maxv;
			end else begin
				sample <= val[shsp_pkg::SAMPLE_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/selective_hue_saturation_pixel_top.sv]
// Top level: selective hue/saturation pixel adjust, six-stage pipeline.
// An accepted input beat passes through stages 1 to 6 in order; stage 6 drives out_valid.
// Throughput: one pixel per clock while out_stall is low; stage 1 holds the nine matrix products, stage 2 the
// strength scale, stage 3 one blend multiply per lane.
// Stalls back up stage by stage; a stage with no beat keeps taking new ones.
// Reset clears all stage valid bits and loads the identity matrix,
// all six hue classes, strength 1.0 and 8-bit samples.
`default_nettype none

module selective_hue_saturation_pixel_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pixel input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire shsp_pkg::pix_in_t    in_data,
	// pixel output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output shsp_pkg::pix_out_t        out_data,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [shsp_pkg::CFG_W-1:0] cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [shsp_pkg::CFG_W-1:0] coef_q [3];
	logic [5:0]                 select_q;
	logic [14:0]                strength_q;
	logic                       wide_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0]  <= 60'h0000_0000_0001_0000;
			coef_q[1]  <= 60'h0000_0010_0000_0000;
			coef_q[2]  <= 60'h0100_0000_0000_0000;
			select_q   <= shsp_pkg::ALL_CLASSES;
			strength_q <= 15'd256;
			wide_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				shsp_pkg::CFG_COEF_RED:   coef_q[0]  <= cfg_data;
				shsp_pkg::CFG_COEF_GREEN: coef_q[1]  <= cfg_data;
				shsp_pkg::CFG_COEF_BLUE:  coef_q[2]  <= cfg_data;
				shsp_pkg::CFG_SELECT:     select_q   <= cfg_data[5:0];
				shsp_pkg::CFG_STRENGTH:   strength_q <= cfg_data[14:0];
				shsp_pkg::CFG_WIDE:       wide_q     <= cfg_data[0];
				default: ;  // unused indexes drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage advance chain: a stage moves when it is empty or its
	// successor moves. Stage 6 is the output register.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2;
	shsp_pkg::stage_en_t en_lane;

	assign en_lane.s6 = !v_s6 || !out_stall;
	assign en_lane.s5 = !v_s5 || en_lane.s6;
	assign en_lane.s4 = !v_s4 || en_lane.s5;
	assign en_lane.s3 = !v_s3 || en_lane.s4;
	assign en_s2      = !v_s2 || en_lane.s3;
	assign en_s1      = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1)      v_s1 <= in_valid;
			if (en_s2)      v_s2 <= v_s1;
			if (en_lane.s3) v_s3 <= v_s2;
			if (en_lane.s4) v_s4 <= v_s3;
			if (en_lane.s5) v_s5 <= v_s4;
			if (en_lane.s6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: sample masking, nine matrix products, hue classes and
	// the raw weight f (largest margin over the selected classes).
	// ------------------------------------------------------------------
	logic [shsp_pkg::SAMPLE_W-1:0] pix [3];
	logic signed [shsp_pkg::COEF_W-1:0] wgt [3][3];
	logic signed [36:0] mul [3][3];
	logic [shsp_pkg::SAMPLE_W-1:0] mx, mn, mx_gb, mx_rb, mx_rg;
	logic [shsp_pkg::SAMPLE_W-1:0] mn_gb, mn_rg, mn_rb;
	logic signed [16:0] margin [6];
	logic [5:0]  flags;
	logic        hit;
	logic [shsp_pkg::SAMPLE_W-1:0] fbest;

	assign pix[0] = wide_q ? in_data.red_in   : {8'd0, in_data.red_in[7:0]};
	assign pix[1] = wide_q ? in_data.green_in : {8'd0, in_data.green_in[7:0]};
	assign pix[2] = wide_q ? in_data.blue_in  : {8'd0, in_data.blue_in[7:0]};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				wgt[j][k] = $signed(coef_q[j][shsp_pkg::COEF_W*k +: shsp_pkg::COEF_W]);
				mul[j][k] = $signed({1'b0, pix[k]}) * wgt[j][k];
			end
		end
	end

	assign mx_gb = (pix[1] > pix[2]) ? pix[1] : pix[2];
	assign mx_rb = (pix[0] > pix[2]) ? pix[0] : pix[2];
	assign mx_rg = (pix[0] > pix[1]) ? pix[0] : pix[1];
	assign mn_gb = (pix[1] < pix[2]) ? pix[1] : pix[2];
	assign mn_rg = (pix[0] < pix[1]) ? pix[0] : pix[1];
	assign mn_rb = (pix[0] < pix[2]) ? pix[0] : pix[2];
	assign mx    = (pix[0] > mx_gb) ? pix[0] : mx_gb;
	assign mn    = (pix[0] < mn_gb) ? pix[0] : mn_gb;

	// ties set every class whose comparison holds
	assign flags = {pix[1] == mn, pix[2] == mx, pix[0] == mn,
	                pix[1] == mx, pix[2] == mn, pix[0] == mx};
	assign hit   = |(flags & select_q);

	// class margins: red, yellow, green, cyan, blue, magenta
	assign margin[0] = $signed({1'b0, pix[0]}) - $signed({1'b0, mx_gb});
	assign margin[1] = $signed({1'b0, mn_rg})  - $signed({1'b0, pix[2]});
	assign margin[2] = $signed({1'b0, pix[1]}) - $signed({1'b0, mx_rb});
	assign margin[3] = $signed({1'b0, mn_gb})  - $signed({1'b0, pix[0]});
	assign margin[4] = $signed({1'b0, pix[2]}) - $signed({1'b0, mx_rg});
	assign margin[5] = $signed({1'b0, mn_rb})  - $signed({1'b0, pix[1]});

	always_comb begin
		fbest = '0;
		for (int c = 0; c < 6; c++) begin
			if (select_q[c] && (margin[c] > $signed({1'b0, fbest}))) begin
				fbest = margin[c][shsp_pkg::SAMPLE_W-1:0];
			end
		end
	end

	logic signed [36:0]            mul_s1 [3][3];
	logic [shsp_pkg::SAMPLE_W-1:0] v0_s1 [3];
	logic [shsp_pkg::SAMPLE_W-1:0] fraw_s1;
	logic                          direct_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mul_s1    <= mul;
			v0_s1     <= pix;
			// a missed mask means f = 0, which leaves the sample unchanged
			fraw_s1   <= hit ? fbest : '0;
			direct_s1 <= (strength_q >= shsp_pkg::STRONG_GAIN)
				&& (select_q == shsp_pkg::ALL_CLASSES);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: row sums with Q16 floor shift; f scaled by strength and
	// capped at the largest sample value.
	// ------------------------------------------------------------------
	logic signed [38:0] row_sum [3];
	logic [30:0] f_scaled;
	logic [22:0] f_shr;
	logic [shsp_pkg::SAMPLE_W-1:0] maxv;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			row_sum[j] = $signed({{2{mul_s1[j][0][36]}}, mul_s1[j][0]})
				+ $signed({{2{mul_s1[j][1][36]}}, mul_s1[j][1]})
				+ $signed({{2{mul_s1[j][2][36]}}, mul_s1[j][2]});
		end
	end

	assign maxv     = wide_q ? 16'hFFFF : 16'h00FF;
	assign f_scaled = fraw_s1 * strength_q;
	assign f_shr    = f_scaled[30:8];

	logic signed [shsp_pkg::MAT_W-1:0] m_s2 [3];
	logic [shsp_pkg::SAMPLE_W-1:0]     v0_s2 [3];
	logic [shsp_pkg::SAMPLE_W-1:0]     fs_s2;
	logic                              direct_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int j = 0; j < 3; j++) begin
				m_s2[j] <= row_sum[j][38:16];  // arithmetic >> 16 floors
			end
			v0_s2     <= v0_s1;
			fs_s2     <= (f_shr > {7'd0, maxv}) ? maxv : f_shr[shsp_pkg::SAMPLE_W-1:0];
			direct_s2 <= direct_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 to 6: one blend lane per channel.
	// ------------------------------------------------------------------
	logic [shsp_pkg::SAMPLE_W-1:0] sample [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		shsp_blend_lane u_lane (
			.clk    (clk),
			.en     (en_lane),
			.wide   (wide_q),
			.direct (direct_s2),
			.m      (m_s2[ch]),
			.v0     (v0_s2[ch]),
			.fs     (fs_s2),
			.sample (sample[ch])
		);
	end

	assign out_data.red_out   = sample[0];
	assign out_data.green_out = sample[1];
	assign out_data.blue_out  = sample[2];

`ifndef SYNTHESIS
	// input only stalls when every stage holds a beat
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled with an empty stage");

	// an open output lets the whole pipe flow
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// a held mid-pipe beat is not dropped
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_lane.s3) |=> v_s3)
		else $error("stage 3 beat lost during stall");
`endif

endmodule

`default_nettype wire

[tb/sv/shsp_checker.sv]
// Pixel channel monitor: shadows the config registers, predicts each output beat, compares.
`default_nettype none

module shsp_checker
	import shsp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire pix_in_t          in_data,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire pix_out_t         out_data,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// shadow copy of the block's registers
	logic [CFG_W-1:0] coef_r_q, coef_g_q, coef_b_q;
	logic [5:0]       select_q;
	logic [14:0]      gain_q;
	logic             wide_q;

	pix_out_t expected_px_q[$];
	pix_out_t want;
	int       fails;
	int       checked;

	function automatic longint max_l(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint min_l(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	// one matrix row: three signed Q16 weights, floor shift by 16
	function automatic longint matrix_row(logic [CFG_W-1:0] row, longint r, longint g,
			longint b);
		logic signed [COEF_W-1:0] wr, wg, wb;
		longint acc;
		wr = row[19:0];
		wg = row[39:20];
		wb = row[59:40];
		acc = r * longint'(wr) + g * longint'(wg) + b * longint'(wb);
		return acc >>> 16;
	endfunction

	function automatic longint move_toward(longint v0, longint v1, longint f, logic wide);
		longint d;
		d = (v1 - v0) * f;
		if (wide) begin
			return v0 + d / 64'sd65535;
		end
		return v0 + (((d + 64'sd128) * 64'sd257) >>> 16);
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_sample(longint v, longint ceil_v);
		longint c;
		c = (v < 0) ? 64'sd0 : ((v > ceil_v) ? ceil_v : v);
		return c[SAMPLE_W-1:0];
	endfunction

	function automatic pix_out_t adjust_pixel(pix_in_t px);
		longint   r, g, b, mr, mg, mb, mx, mn, f, ceil_v, o_r, o_g, o_b;
		logic [5:0] flags;
		pix_out_t res;
		ceil_v = wide_q ? 64'sd65535 : 64'sd255;
		r = wide_q ? longint'(px.red_in)   : longint'(px.red_in[7:0]);
		g = wide_q ? longint'(px.green_in) : longint'(px.green_in[7:0]);
		b = wide_q ? longint'(px.blue_in)  : longint'(px.blue_in[7:0]);
		mr = matrix_row(coef_r_q, r, g, b);
		mg = matrix_row(coef_g_q, r, g, b);
		mb = matrix_row(coef_b_q, r, g, b);
		o_r = r;
		o_g = g;
		o_b = b;
		if (gain_q >= STRONG_GAIN && select_q == ALL_CLASSES) begin
			o_r = mr;
			o_g = mg;
			o_b = mb;
		end else begin
			mx = max_l(r, max_l(g, b));
			mn = min_l(r, min_l(g, b));
			flags[0] = (r == mx);
			flags[1] = (b == mn);
			flags[2] = (g == mx);
			flags[3] = (r == mn);
			flags[4] = (b == mx);
			flags[5] = (g == mn);
			if ((select_q & flags) != 6'd0) begin
				f = 0;
				if (select_q[0]) f = max_l(f, r - max_l(g, b));
				if (select_q[1]) f = max_l(f, min_l(r, g) - b);
				if (select_q[2]) f = max_l(f, g - max_l(r, b));
				if (select_q[3]) f = max_l(f, min_l(g, b) - r);
				if (select_q[4]) f = max_l(f, b - max_l(r, g));
				if (select_q[5]) f = max_l(f, min_l(r, b) - g);
				f = (f * longint'(gain_q)) >>> 8;
				f = min_l(f, ceil_v);
				o_r = move_toward(r, mr, f, wide_q);
				o_g = move_toward(g, mg, f, wide_q);
				o_b = move_toward(b, mb, f, wide_q);
			end
		end
		res.red_out   = clamp_sample(o_r, ceil_v);
		res.green_out = clamp_sample(o_g, ceil_v);
		res.blue_out  = clamp_sample(o_b, ceil_v);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_r_q = CFG_W'(65536);
			coef_g_q = CFG_W'(65536) << 20;
			coef_b_q = CFG_W'(65536) << 40;
			select_q = ALL_CLASSES;
			gain_q   = 15'd256;
			wide_q   = 1'b0;
			expected_px_q.delete();
			fails   = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_px_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("%0t: output beat with nothing expected: r=%h g=%h b=%h",
							$realtime, out_data.red_out, out_data.green_out,
							out_data.blue_out);
				end else begin
					want = expected_px_q.pop_front();
					checked++;
					if (out_data.red_out !== want.red_out ||
							out_data.green_out !== want.green_out ||
							out_data.blue_out !== want.blue_out) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("%0t: pixel %0d mismatch: want r=%h g=%h b=%h, got r=%h g=%h b=%h",
								$realtime, checked, want.red_out, want.green_out,
								want.blue_out, out_data.red_out, out_data.green_out,
								out_data.blue_out);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_px_q.push_back(adjust_pixel(in_data));
			if (cfg_we) begin
				case (cfg_index)
					CFG_COEF_RED:   coef_r_q = cfg_data;
					CFG_COEF_GREEN: coef_g_q = cfg_data;
					CFG_COEF_BLUE:  coef_b_q = cfg_data;
					CFG_SELECT:     select_q = cfg_data[5:0];
					CFG_STRENGTH:   gain_q   = cfg_data[14:0];
					CFG_WIDE:       wide_q   = cfg_data[0];
					default: ;
				endcase
			end
		end
		fail_count    <= fails;
		pending       <= expected_px_q.size();
		checked_count <= checked;
	end

endmodule

`default_nettype wire

[tb/sv/tb_selective_hue_saturation_pixel_top.sv]
// Testbench top: drives pixels and register writes into the hue/saturation block.
`default_nettype none

module tb_selective_hue_saturation_pixel_top;
	timeunit 1ns;
	timeprecision 1ps;
	import shsp_pkg::*;

	localparam int SEGMENTS     = 8;
	localparam int SEG_PIXELS   = 65;
	localparam int DIR_PIXELS   = 12;
	localparam int HOLD_CYCLES  = 160;   // long receiver hold-off, pipe is only ~6 deep
	localparam int LATENCY_PAD  = 12;    // quiet cycles after the last beat, > pipe latency
	localparam int DRAIN_LIMIT  = 5000;
	// indexes past the register list; writes there must be ignored
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	pix_in_t          in_data;
	logic             out_valid;
	logic             out_stall = 1'b0;
	pix_out_t         out_data;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fail_count, pending, checked_count;

	// idle knobs, percent per cycle
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// hold-off handshake between stimulus and receiver: one writer each
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;

	int items_sent    = 0;
	int settings_used = 1;   // reset values count as the first setting

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	selective_hue_saturation_pixel_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	shsp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count)
	);

	// Receiver: random stall, or a counted hold-off when the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_reqs != hold_done) begin
			hold_done = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// Hard stop in case the block wedges.
	initial begin
		#2_000_000;
		$display("timeout: %0d beats still expected", pending);
		$display("[selective_hue_saturation_pixel_top] ERROR");
		$finish;
	end

	// Pack three signed Q16 weights into one row register, red weight in the low bits.
	function automatic logic [CFG_W-1:0] pack_row(int wr, int wg, int wb);
		return {wb[19:0], wg[19:0], wr[19:0]};
	endfunction

	function automatic logic [CFG_W-1:0] rand_row();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[CFG_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] edge_sample();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h00FF;
			default: return 16'hFF00;
		endcase
	endfunction

	// Hand-picked pixels: black, white, wide values in 8-bit mode, each hue class, ties.
	function automatic pix_in_t directed_pixel(int k);
		pix_in_t p;
		case (k)
			0:       p = {16'h0000, 16'h0000, 16'h0000};
			1:       p = {16'h00FF, 16'h00FF, 16'h00FF};
			2:       p = {16'hFFFF, 16'hFFFF, 16'hFFFF};
			3:       p = {16'h00FF, 16'h0000, 16'h0000};   // red
			4:       p = {16'h00FF, 16'h00FF, 16'h0000};   // yellow
			5:       p = {16'h0000, 16'h00FF, 16'h0000};   // green
			6:       p = {16'h0000, 16'h00FF, 16'h00FF};   // cyan
			7:       p = {16'h0000, 16'h0000, 16'h00FF};   // blue
			8:       p = {16'h00FF, 16'h0000, 16'h00FF};   // magenta
			9:       p = {16'h0080, 16'h0080, 16'h0010};   // red/green tie at max
			10:      p = {16'h1234, 16'hABCD, 16'hFF00};   // upper bits set
			default: p = {16'h0010, 16'h00F0, 16'h0070};
		endcase
		return p;
	endfunction

	// Random pixel: mostly free values, with ties, gray, near-gray and edge samples mixed in.
	function automatic pix_in_t make_pixel();
		pix_in_t     p;
		logic [31:0] a, b;
		a = $urandom;
		b = $urandom;
		p = {a[15:0], a[31:16], b[15:0]};
		case ($urandom_range(9))
			6: p.green_in = p.red_in;
			7: begin
				p.green_in = p.red_in;
				p.blue_in  = p.red_in;
			end
			8: begin
				p.red_in   = edge_sample();
				p.green_in = edge_sample();
				p.blue_in  = edge_sample();
			end
			9: begin
				p.green_in = p.red_in ^ {12'h000, b[19:16]};
				p.blue_in  = p.red_in ^ {12'h000, b[23:20]};
			end
			default: ;
		endcase
		return p;
	endfunction

	// Present one beat at the falling edge; hold it until the block takes it.
	// Valid stays high into the next beat unless an idle cycle is drawn.
	task automatic offer_pixel(input pix_in_t px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = px;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stop sending and wait until every predicted pixel has come out.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0:       begin send_idle_pct = 0;  stall_pct = 0;  end
			1:       begin send_idle_pct = 81; stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  stall_pct = 81; end
			default: begin send_idle_pct = 22; stall_pct = 22; end
		endcase
	endtask

	// Per-segment register setting. Covers the direct matrix path (strength >= 99
	// with all classes), just below it, zero and over-range strength, empty and
	// partial class masks, extreme weights, and both sample widths.
	task automatic configure_segment(input int seg);
		logic [CFG_W-1:0] cr, cg, cb, sat_r, sat_g, sat_b;
		logic [5:0]       sel;
		logic [14:0]      gain;
		logic             wide;
		logic [31:0]      rnd;
		rnd   = $urandom;
		sat_r = pack_row(106496, -53248, -53248);   // 1.625 / -0.8125 saturation boost
		sat_g = pack_row(-53248, 106496, -53248);
		sat_b = pack_row(-53248, -53248, 106496);
		cr    = rand_row();
		cg    = rand_row();
		cb    = rand_row();
		sel   = rnd[5:0];
		gain  = 15'($urandom_range(25600));
		case (seg)
			0: begin sel = ALL_CLASSES; gain = STRONG_GAIN; wide = 1'b0; end
			1: wide = 1'b1;
			2: begin
				cr   = {20'h80000, 20'h7FFFF, 20'h7FFFF};
				cg   = {20'h7FFFF, 20'h80000, 20'h7FFFF};
				cb   = {20'h80000, 20'h80000, 20'h7FFFF};
				sel  = (rnd[5:0] == 6'd0) ? 6'h21 : rnd[5:0];
				gain = 15'h7FFF;
				wide = 1'b0;
			end
			3: begin
				cr = sat_r; cg = sat_g; cb = sat_b;
				sel = ALL_CLASSES; gain = STRONG_GAIN - 15'd1; wide = 1'b1;
			end
			4: begin sel = 6'h00; gain = 15'd256; wide = 1'b0; end
			5: begin
				cr   = {20'h7FFFF, 20'h80000, 20'h80000};
				cg   = {20'h80000, 20'h7FFFF, 20'h80000};
				cb   = {20'h7FFFF, 20'h7FFFF, 20'h80000};
				sel  = ALL_CLASSES;
				gain = 15'h7FFF;
				wide = 1'b1;
			end
			6: begin gain = 15'd0; wide = 1'b0; end
			default: begin cr = sat_r; cg = sat_g; cb = sat_b; wide = 1'b1; end
		endcase
		write_reg(CFG_COEF_RED,   cr);
		write_reg(CFG_COEF_GREEN, cg);
		write_reg(CFG_COEF_BLUE,  cb);
		write_reg(CFG_SELECT,     CFG_W'(sel));
		write_reg(CFG_STRENGTH,   CFG_W'(gain));
		write_reg(CFG_WIDE,       CFG_W'(wide));
		settings_used++;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_COEF_RED;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass 1: reset registers (identity, all classes, strength 1.0, 8-bit).
		set_idle_mode(0);
		for (int k = 0; k < DIR_PIXELS; k++)
			offer_pixel(directed_pixel(k));
		wait_for_drain();

		// Directed pass 2: saturation matrix, three primaries only, strength far
		// above 100 so the weight hits its cap. Spare indexes get junk that must
		// change nothing.
		write_reg(CFG_COEF_RED,   pack_row(106496, -53248, -53248));
		write_reg(CFG_COEF_GREEN, pack_row(-53248, 106496, -53248));
		write_reg(CFG_COEF_BLUE,  pack_row(-53248, -53248, 106496));
		write_reg(CFG_SELECT,     CFG_W'(6'h15));
		write_reg(CFG_STRENGTH,   CFG_W'(15'h7FFF));
		write_reg(CFG_SPARE_LO,   '1);
		write_reg(CFG_SPARE_HI,   rand_row());
		settings_used++;
		for (int k = 0; k < DIR_PIXELS; k++)
			offer_pixel(directed_pixel(k));
		wait_for_drain();

		// Random segments, each with its own register setting and idle pattern.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			configure_segment(seg);
			set_idle_mode(seg % 4);
			for (int n = 0; n < SEG_PIXELS; n++) begin
				// segment 0 runs without idling: a long receiver hold-off here
				// fills the pipe and must push back on the input
				if (seg == 0 && n == 10)
					hold_reqs++;
				// mid-segment pause until the pipe is empty, then resume
				if (seg == 1 && n == 30)
					wait_for_drain();
				offer_pixel(make_pixel());
			end
			wait_for_drain();
		end

		// Final drain with a bound, then some quiet cycles to catch stray beats.
		@(negedge clk);
		in_valid = 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending != 0; i++)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);

		$display("run covered %0d pixels under %0d register settings, 8- and 16-bit samples,",
			items_sent, settings_used);
		$display("direct matrix and hue-gated blend paths, four idle patterns and a long hold-off; %0d beats compared",
			checked_count);
		if (fail_count == 0 && pending == 0) begin
			$display("[selective_hue_saturation_pixel_top] OK");
		end else begin
			$display("%0d failures, %0d beats never arrived", fail_count, pending);
			$display("[selective_hue_saturation_pixel_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
